FILE: rtl/vea_pkg.sv
// Package for the variable extent allocator: sizes, codes, state encoding.
// Used by every file under rtl; depends on nothing.
package vea_pkg;
	localparam int MaxExtents = 32;
	localparam int MaxLive    = 16;
	localparam int AddrBits   = 16;
	localparam int ExtBits    = $clog2(MaxExtents);
	localparam int LiveBits   = $clog2(MaxLive);

	localparam logic [15:0] MemSizeReset  = 16'd1024;
	localparam logic [7:0]  MinSliceReset = 8'd10;

	localparam logic [1:0] RegMemSize  = 2'd0;
	localparam logic [1:0] RegFitMode  = 2'd1;
	localparam logic [1:0] RegMinSlice = 2'd2;

	localparam logic [1:0] FitBest  = 2'd0;
	localparam logic [1:0] FitWorst = 2'd2;

	localparam logic [2:0] StOk      = 3'd0;
	localparam logic [2:0] StNoSpace = 3'd1;
	localparam logic [2:0] StBadSize = 3'd2;
	localparam logic [2:0] StUnknown = 3'd3;
	localparam logic [2:0] StFull    = 3'd4;

	typedef struct packed {
		logic [AddrBits-1:0] start;
		logic [AddrBits-1:0] len;
	} ext_t;

	typedef struct packed {
		logic [15:0]         id;
		logic [AddrBits-1:0] start;
		logic [AddrBits-1:0] len;
	} live_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] id;
		logic [15:0] start;
		logic [15:0] size;
	} res_t;

	typedef enum logic [3:0] {
		S_IDLE, S_LSCAN, S_LCHK, S_FSCAN, S_FLAST, S_APPLY,
		S_MWR1, S_MWR2, S_OUT
	} state_t;
endpackage

FILE: rtl/vea_core.sv
// Sequencer of the allocator: owns the free and live memories and scans them.
// Depends on vea_pkg.
module vea_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   func,
	input  logic [15:0]            req_size,
	input  logic [15:0]            req_id,
	input  logic [15:0]            pool_units,
	input  logic [1:0]             fit_mode,
	input  logic [7:0]             spare_max,
	input  logic                   res_ready,
	output logic                   busy,
	output logic                   done,
	output vea_pkg::res_t          res
);
	import vea_pkg::*;

	ext_t  fmem [MaxExtents];
	live_t lmem [MaxLive];
	logic [MaxExtents-1:0] fvalid_q;
	logic [MaxLive-1:0]    lvalid_q;

	state_t state_q, state_d;
	logic [ExtBits:0]  idx_q;
	ext_t  frd_s1;
	live_t lrd_s1;
	logic [ExtBits-1:0] rd_prev_q;
	logic              func_q;
	logic [15:0]       want_q, rid_q, next_id_q;
	logic              ever_q;
	logic              slot_ok_q, hit_ok_q, best_ok_q, prev_ok_q, nxt_ok_q, fs_ok_q;
	logic [LiveBits-1:0] slot_q, hit_q;
	logic [ExtBits-1:0]  best_q, prev_q, nxt_q, fs_q;
	ext_t  best_e_q, prev_e_q, nxt_e_q;
	logic [15:0] gstart_q, glen_q;
	res_t  res_q, res_d;
	logic  reload, keep_rest;

	// read address follows the scan index
	always_ff @(posedge clk) begin
		frd_s1 <= fmem[idx_q[ExtBits-1:0]];
		lrd_s1 <= lmem[idx_q[LiveBits-1:0]];
	end

	logic fv_s1, lv_s1;
	assign fv_s1 = fvalid_q[rd_prev_q];
	assign lv_s1 = lvalid_q[rd_prev_q[LiveBits-1:0]];

	logic take;
	logic [AddrBits-1:0] want_a, end_a;
	assign want_a = want_q;
	assign end_a  = gstart_q + glen_q;
	always_comb begin
		take = 1'b0;
		if (fv_s1 && frd_s1.len >= want_a) begin
			if (!best_ok_q) take = 1'b1;
			else if (fit_mode == FitBest)
				take = frd_s1.len < best_e_q.len ||
					(frd_s1.len == best_e_q.len && frd_s1.start < best_e_q.start);
			else if (fit_mode == FitWorst)
				take = frd_s1.len > best_e_q.len ||
					(frd_s1.len == best_e_q.len && frd_s1.start < best_e_q.start);
			else take = frd_s1.start < best_e_q.start;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (start) state_d = S_LSCAN;
			S_LSCAN: if (idx_q == ExtBits'(0) + (ExtBits+1)'(MaxLive)) state_d = S_LCHK;
			S_LCHK: begin
				if (!func_q) begin
					if (want_q == 16'd0 || !slot_ok_q) state_d = S_OUT;
					else state_d = S_FSCAN;
				end else if (!hit_ok_q) state_d = S_OUT;
				else state_d = S_FSCAN;
			end
			S_FSCAN: if (idx_q == (ExtBits+1)'(MaxExtents)) state_d = S_FLAST;
			S_FLAST: state_d = S_APPLY;
			S_APPLY: state_d = func_q ? S_MWR1 : S_OUT;
			S_MWR1:  state_d = S_MWR2;
			S_MWR2:  state_d = S_OUT;
			// hold until the result register can take the item
			S_OUT:   if (res_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_OUT && res_ready;
	assign res  = res_q;

	assign reload    = state_q == S_IDLE && start && !func && !ever_q;
	assign keep_rest = (best_e_q.len - want_a) > AddrBits'(spare_max);

	logic scan_hit;
	assign scan_hit = (state_q == S_LSCAN || state_q == S_LCHK) && idx_q != '0;

	logic fscan_rd;
	assign fscan_rd = (state_q == S_FSCAN && idx_q != '0) || state_q == S_FLAST;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			fvalid_q <= '0;
			lvalid_q <= '0;
			next_id_q <= '0;
			ever_q <= 1'b0;
			rd_prev_q <= '0;
		end else begin
			state_q <= state_d;
			rd_prev_q <= idx_q[ExtBits-1:0];
			unique case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					// reload the whole-memory extent until something is allocated
					if (reload) fvalid_q <= MaxExtents'(pool_units != 16'd0);
				end
				S_LSCAN: idx_q <= idx_q + 1'b1;
				S_LCHK:  idx_q <= '0;
				S_FSCAN: idx_q <= idx_q + 1'b1;
				S_APPLY: begin
					if (!func_q) begin
						if (best_ok_q) begin
							if (!keep_rest) fvalid_q[best_q] <= 1'b0;
							lvalid_q[slot_q] <= 1'b1;
							next_id_q <= next_id_q + 16'd1;
							ever_q <= 1'b1;
						end
					end else begin
						lvalid_q[hit_q] <= 1'b0;
						if (prev_ok_q && nxt_ok_q) fvalid_q[nxt_q] <= 1'b0;
						else if (!prev_ok_q && !nxt_ok_q && fs_ok_q) fvalid_q[fs_q] <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (reload) fmem[0] <= '{start: '0, len: AddrBits'(pool_units)};
		if (state_q == S_APPLY) begin
			if (!func_q) begin
				if (best_ok_q) begin
					if (keep_rest)
						fmem[best_q] <= '{start: best_e_q.start + want_a,
							len: best_e_q.len - want_a};
					lmem[slot_q] <= '{id: next_id_q, start: gstart_q, len: glen_q};
				end
			end else if (prev_ok_q)
				fmem[prev_q] <= '{start: prev_e_q.start, len: prev_e_q.len + glen_q
					+ (nxt_ok_q ? nxt_e_q.len : '0)};
			else if (nxt_ok_q)
				fmem[nxt_q] <= '{start: gstart_q, len: nxt_e_q.len + glen_q};
			else if (fs_ok_q)
				fmem[fs_q] <= '{start: gstart_q, len: glen_q};
		end
	end

	always_comb begin
		res_d = '0;
		if (!func_q) begin
			if (want_q == 16'd0) res_d.status = StBadSize;
			else if (!slot_ok_q) res_d.status = StFull;
			else if (!best_ok_q) res_d.status = StNoSpace;
			else begin
				res_d.status = StOk; res_d.id = next_id_q;
				res_d.start = gstart_q; res_d.size = glen_q;
			end
		end else if (!hit_ok_q) res_d.status = StUnknown;
		else begin
			res_d.status = StOk; res_d.start = gstart_q; res_d.size = glen_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start && state_q == S_IDLE) begin
			func_q <= func; want_q <= req_size; rid_q <= req_id;
			slot_ok_q <= 1'b0; hit_ok_q <= 1'b0; best_ok_q <= 1'b0;
			prev_ok_q <= 1'b0; nxt_ok_q <= 1'b0; fs_ok_q <= 1'b0;
		end
		if (scan_hit) begin
			if (!lv_s1 && !slot_ok_q) begin
				slot_ok_q <= 1'b1; slot_q <= rd_prev_q[LiveBits-1:0];
			end
			if (lv_s1 && lrd_s1.id == rid_q && !hit_ok_q) begin
				hit_ok_q <= 1'b1; hit_q <= rd_prev_q[LiveBits-1:0];
				gstart_q <= lrd_s1.start; glen_q <= lrd_s1.len;
			end
		end
		if (fscan_rd) begin
			if (!func_q) begin
				if (take) begin
					best_ok_q <= 1'b1; best_q <= rd_prev_q; best_e_q <= frd_s1;
					gstart_q <= frd_s1.start;
					glen_q <= ((frd_s1.len - want_a) > AddrBits'(spare_max))
						? want_a : frd_s1.len;
				end
			end else if (!fv_s1) begin
				if (!fs_ok_q) begin fs_ok_q <= 1'b1; fs_q <= rd_prev_q; end
			end else if (!prev_ok_q && frd_s1.start + frd_s1.len == gstart_q) begin
				prev_ok_q <= 1'b1; prev_q <= rd_prev_q; prev_e_q <= frd_s1;
			end else if (!nxt_ok_q && frd_s1.start == end_a) begin
				nxt_ok_q <= 1'b1; nxt_q <= rd_prev_q; nxt_e_q <= frd_s1;
			end
		end
		if (state_q == S_LCHK || state_q == S_APPLY) res_q <= res_d;
	end
endmodule

FILE: rtl/variable_extent_allocator.sv
// Top level of the variable extent allocator: stream ports, registers, output.
// Depends on vea_pkg and vea_core.
//  channel  dir  width  content
//  s_axis   in   33     request item
//  m_axis   out  56     result item
//  cfg      in   19     register write
// An allocate runs a live table scan, a check, a free table scan through
// registered memory reads, a drain of the last read, an update, an output and
// an idle state before the next accept. A free adds two write states after the
// update; errors found by the live scan go from the check straight to output.
// Reset clears valid bits, ids and control; table contents stay undefined.
// A held result lets the next request run; the core then waits in its output
// state until the result register is free.
module variable_extent_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // req_size[15:0], req_id[31:16]
	input  logic        s_axis_tuser,  // func
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,  // status[2:0], grant_id, grant_start, grant_size
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import vea_pkg::*;

	logic [15:0] pool_units_q;
	logic [1:0]  fit_mode_q;
	logic [7:0]  spare_max_q;
	logic busy, done, start, ov_q, res_ready;
	res_t res, out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_units_q <= MemSizeReset; fit_mode_q <= '0; spare_max_q <= MinSliceReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegMemSize:  pool_units_q <= cfg_data;
				RegFitMode:  fit_mode_q <= cfg_data[1:0];
				RegMinSlice: spare_max_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// accept while core is idle
	assign s_axis_tready = !busy;
	assign start = s_axis_tvalid && s_axis_tready;
	assign res_ready = !ov_q || m_axis_tready;

	vea_core u_core (
		.clk, .arst_n, .start, .func(s_axis_tuser),
		.req_size(s_axis_tdata[15:0]), .req_id(s_axis_tdata[31:16]),
		.pool_units(pool_units_q), .fit_mode(fit_mode_q), .spare_max(spare_max_q),
		.res_ready, .busy, .done, .res
	);

	// hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (done) ov_q <= 1'b1;
		else if (m_axis_tready) ov_q <= 1'b0;
	end
	always_ff @(posedge clk) if (done) out_q <= res;

	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata = {5'd0, out_q.size, out_q.start, out_q.id, out_q.status};
endmodule

FILE: test/tb.sv
// Testbench for the variable extent allocator: random and directed requests
// checked against an in-bench model of the free and live tables.
// Depends on vea_pkg and variable_extent_allocator.
`timescale 1ns / 100ps

module tb;
	import vea_pkg::*;

	localparam int Limit = 20000;
	localparam logic FuncAlloc = 1'b0;
	localparam logic FuncFree  = 1'b1;
	localparam logic [1:0] FitFirst = 2'd1;

	typedef struct packed {
		logic        func;
		logic [15:0] size;
		logic [15:0] id;
	} req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	variable_extent_allocator u_top (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// model state
	logic [15:0] m_mem;
	logic [1:0]  m_fit;
	logic [7:0]  m_slice;
	logic [15:0] f_start [MaxExtents];
	logic [15:0] f_len [MaxExtents];
	logic        f_ok [MaxExtents];
	logic [15:0] l_id [MaxLive];
	logic [15:0] l_start [MaxLive];
	logic [15:0] l_len [MaxLive];
	logic        l_ok [MaxLive];
	logic [15:0] id_next;
	logic        allocated;

	req_t pending_reqs [$];
	res_t expected_results [$];
	int errors = 0;
	int idle_cycles = 0;
	int rx_hold_left = 0;

	function automatic int pick_extent(logic [15:0] want);
		int pick;
		bit take;
		pick = -1;
		for (int i = 0; i < MaxExtents; i++) begin
			if (!f_ok[i] || f_len[i] < want) continue;
			if (pick < 0) take = 1'b1;
			else if (m_fit == FitBest)
				take = f_len[i] < f_len[pick] ||
					(f_len[i] == f_len[pick] && f_start[i] < f_start[pick]);
			else if (m_fit == FitWorst)
				take = f_len[i] > f_len[pick] ||
					(f_len[i] == f_len[pick] && f_start[i] < f_start[pick]);
			else take = f_start[i] < f_start[pick];
			if (take) pick = i;
		end
		return pick;
	endfunction

	function automatic void merge_back(logic [15:0] s, logic [15:0] l);
		int prv, nxt, slot;
		prv = -1; nxt = -1; slot = -1;
		for (int i = 0; i < MaxExtents; i++) begin
			if (!f_ok[i]) begin
				if (slot < 0) slot = i;
			end else if (prv < 0 && 17'(f_start[i]) + f_len[i] == 17'(s)) prv = i;
			else if (nxt < 0 && 17'(f_start[i]) == 17'(s) + l) nxt = i;
		end
		if (prv >= 0 && nxt >= 0) begin
			f_len[prv] = f_len[prv] + l + f_len[nxt];
			f_ok[nxt] = 1'b0;
		end else if (prv >= 0) f_len[prv] = f_len[prv] + l;
		else if (nxt >= 0) begin
			f_start[nxt] = s;
			f_len[nxt] = f_len[nxt] + l;
		end else if (slot >= 0) begin
			f_start[slot] = s;
			f_len[slot] = l;
			f_ok[slot] = 1'b1;
		end
	endfunction

	function automatic res_t allocate_result(req_t r);
		res_t o;
		int slot, e, hit;
		logic [15:0] left;
		o = '0;
		o.status = StOk;
		if (r.func == FuncAlloc) begin
			slot = -1;
			for (int i = MaxLive - 1; i >= 0; i--) if (!l_ok[i]) slot = i;
			if (!allocated) begin
				for (int i = 0; i < MaxExtents; i++) f_ok[i] = 1'b0;
				if (m_mem != 16'd0) begin
					f_start[0] = '0; f_len[0] = m_mem; f_ok[0] = 1'b1;
				end
			end
			e = -1;
			if (r.size == 16'd0) o.status = StBadSize;
			else if (slot < 0) o.status = StFull;
			else begin
				e = pick_extent(r.size);
				if (e < 0) o.status = StNoSpace;
			end
			if (o.status == StOk) begin
				left = f_len[e] - r.size;
				o.start = f_start[e];
				if (left > {8'd0, m_slice}) begin
					f_start[e] = f_start[e] + r.size;
					f_len[e] = left;
					o.size = r.size;
				end else begin
					o.size = f_len[e];
					f_ok[e] = 1'b0;
				end
				o.id = id_next;
				id_next = id_next + 16'd1;
				l_id[slot] = o.id; l_start[slot] = o.start;
				l_len[slot] = o.size; l_ok[slot] = 1'b1;
				allocated = 1'b1;
			end
		end else begin
			hit = -1;
			for (int i = MaxLive - 1; i >= 0; i--) if (l_ok[i] && l_id[i] == r.id) hit = i;
			if (hit < 0) o.status = StUnknown;
			else begin
				o.start = l_start[hit];
				o.size = l_len[hit];
				l_ok[hit] = 1'b0;
				merge_back(o.start, o.size);
			end
		end
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	// driver
	int tx_wait = 0;
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			expected_results.push_back(allocate_result(pending_reqs.pop_front()));
			tx_wait = $urandom_range(0, 19);
		end
		if (tx_wait > 0 && !(s_axis_tvalid && !s_axis_tready)) begin
			tx_wait--;
			s_axis_tvalid <= 1'b0;
		end else if (pending_reqs.size() > 0 && arst_n) begin
			s_axis_tvalid <= 1'b1;
			s_axis_tuser <= pending_reqs[0].func;
			s_axis_tdata <= {pending_reqs[0].id, pending_reqs[0].size};
		end else s_axis_tvalid <= 1'b0;
	end

	// monitor
	int rx_wait = 0;
	always @(posedge clk) begin
		res_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got.status = m_axis_tdata[2:0];
			got.id     = m_axis_tdata[18:3];
			got.start  = m_axis_tdata[34:19];
			got.size   = m_axis_tdata[50:35];
			if (expected_results.size() == 0)
				report_mismatch("unexpected item status", 16'(got.status), 16'd0);
			else begin
				want = expected_results.pop_front();
				if (got.status != want.status) report_mismatch("status", 16'(got.status), 16'(want.status));
				if (got.id != want.id) report_mismatch("grant_id", got.id, want.id);
				if (got.start != want.start) report_mismatch("grant_start", got.start, want.start);
				if (got.size != want.size) report_mismatch("grant_size", got.size, want.size);
			end
			rx_wait = $urandom_range(0, 19);
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			m_axis_tready <= 1'b0;
		end else if (rx_wait > 0) begin
			rx_wait--;
			m_axis_tready <= 1'b0;
		end else m_axis_tready <= 1'b1;
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= Limit) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || expected_results.size() > 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == RegMemSize) m_mem = val;
		else if (idx == RegFitMode) m_fit = val[1:0];
		else m_slice = val[7:0];
	endtask

	function automatic void push_req(logic func, logic [15:0] size, logic [15:0] id);
		req_t r;
		r.func = func; r.size = size; r.id = id;
		pending_reqs.push_back(r);
	endfunction

	function automatic logic [15:0] rand_size();
		case ($urandom_range(0, 9))
			0: return 16'($urandom);
			1: return 16'd0;
			2: return 16'($urandom_range(1, 4));
			default: return 16'($urandom_range(1, 200));
		endcase
	endfunction

	initial begin
		m_mem = MemSizeReset; m_fit = FitBest; m_slice = MinSliceReset;
		for (int i = 0; i < MaxExtents; i++) begin
			f_ok[i] = 1'b0; f_start[i] = '0; f_len[i] = '0;
		end
		for (int i = 0; i < MaxLive; i++) begin
			l_ok[i] = 1'b0; l_id[i] = '0; l_start[i] = '0; l_len[i] = '0;
		end
		id_next = '0; allocated = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// zero memory size answers no space, then the largest
		write_reg(RegMemSize, 16'd0);
		push_req(FuncAlloc, 16'd5, 16'd0);
		push_req(FuncAlloc, 16'd0, 16'd0);
		push_req(FuncFree, 16'hFFFF, 16'hFFFF);
		wait_drained();
		write_reg(RegMemSize, 16'hFFFF);
		write_reg(RegMinSlice, 16'd255);
		write_reg(RegFitMode, 16'(FitFirst));
		push_req(FuncAlloc, 16'hFFFF, 16'd0);
		push_req(FuncFree, 16'd0, 16'd0);
		push_req(FuncFree, 16'd0, 16'd0);
		for (int i = 0; i < 17; i++) push_req(FuncAlloc, 16'd300, 16'd0);
		for (int i = 0; i < 17; i += 2) push_req(FuncFree, 16'd0, 16'(i + 1));
		wait_drained();
		write_reg(RegMemSize, 16'd4000);

		// random phases across settings
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(RegFitMode, 16'(ph % 4));
			write_reg(RegMinSlice, (ph == 1) ? 16'd0 : (ph == 2) ? 16'd255 :
				16'($urandom_range(0, 40)));
			if (ph == 3) begin
				// stall the receiver while requests keep coming
				rx_hold_left = 600;
				for (int i = 0; i < 6; i++) push_req(FuncAlloc, rand_size(), 16'd0);
			end
			for (int i = 0; i < 135; i++) begin
				if ($urandom_range(0, 1)) push_req(FuncAlloc, rand_size(), 16'($urandom));
				else if ($urandom_range(0, 9) == 0)
					push_req(FuncFree, 16'($urandom), 16'($urandom));
				else push_req(FuncFree, 16'($urandom),
					id_next + 16'($urandom_range(0, 40)) - 16'd30);
			end
			wait_drained();
		end

		if (errors == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end
endmodule
